// File: rtl/core/quote_overlay_reconciler_top_assert.svh
// Assertion macros for the quote overlay reconciler
`ifndef QUOTE_OVERLAY_RECONCILER_TOP_ASSERT_SVH
`define QUOTE_OVERLAY_RECONCILER_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, quiet in reset
`define QOR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, quiet in reset
`define QOR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/qor_pkg.sv
// Types, codes and a helper function of the quote overlay reconciler
package qor_pkg;

    localparam logic [1:0] CMD_TICKER    = 2'd0;
    localparam logic [1:0] CMD_CANONICAL = 2'd1;
    localparam logic [1:0] CMD_QUERY     = 2'd2;

    localparam logic [31:0] DIV_MAX = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ACT_IGNORED     = 3'd0,
        ACT_TICKER_ONLY = 3'd1,
        ACT_UPDATED     = 3'd2,
        ACT_PENDING     = 3'd3,
        ACT_CLEARED     = 3'd4,
        ACT_DIVERGENCE  = 3'd5
    } qor_action_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [31:0]        instrument;
        logic [31:0]        generation;
        logic [63:0]        seq;
        logic [63:0]        stamp;
        logic signed [63:0] bid_price;
        logic signed [63:0] bid_qty;
        logic signed [63:0] ask_price;
        logic signed [63:0] ask_qty;
        logic [31:0]        canon_instrument;
        logic [31:0]        canon_generation;
        logic [63:0]        canon_seq;
    } qor_item_t;

    typedef struct packed {
        qor_action_t        action;
        logic [31:0]        divergences;
        logic               overlay_valid;
        logic               use_overlay;
        logic               canonical_ok;
        logic [63:0]        out_seq;
        logic [63:0]        out_stamp;
        logic signed [63:0] out_bid_price;
        logic signed [63:0] out_bid_qty;
        logic signed [63:0] out_ask_price;
        logic signed [63:0] out_ask_qty;
    } qor_result_t;

    typedef struct packed {
        logic               valid;
        logic [31:0]        instrument;
        logic [31:0]        generation;
        logic [63:0]        seq;
        logic [63:0]        stamp;
        logic signed [63:0] bid_price;
        logic signed [63:0] bid_qty;
        logic signed [63:0] ask_price;
        logic signed [63:0] ask_qty;
    } qor_overlay_t;

    function automatic logic quote_ok(input qor_item_t it);
        quote_ok = !it.bid_price[63] && !it.bid_qty[63] &&
                   !it.ask_price[63] && !it.ask_qty[63] &&
                   (it.bid_price < it.ask_price);
    endfunction

endpackage

// File: rtl/core/quote_overlay_reconciler_top.sv
// Quote overlay reconciler: input register, one-pass update, result register
//
// Channels: item (item_valid/item_ready) carries one qor_item_t beat per
// ticker event, canonical event or effective query; result
// (result_valid/result_ready) returns exactly one qor_result_t beat per item.
// cfg_we/cfg_wdata writes shared_domain; write only while the block is idle.
// An accepted beat moves from the input register to the result register.
// Throughput: one item per cycle while the result port is not stalled; the
// overlay registers, the divergence counter and the result register all
// update in the cycle an item moves from the input to the result register.
// Reset: overlay cleared, divergence count 0, shared_domain 1, both stages
// empty.
// Stall: while result_ready is low the result register holds its beat, the
// input register holds the next item and item_ready drops once both stages
// are full; no beat is lost or repeated.
module quote_overlay_reconciler_top
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic                item_valid,
    output logic                item_ready,
    input  qor_pkg::qor_item_t   item,
    output logic                result_valid,
    input  logic                result_ready,
    output qor_pkg::qor_result_t result
);
    import qor_pkg::*;

    `include "quote_overlay_reconciler_top_assert.svh"

    logic         shared_reg;
    logic         item_valid_reg;
    qor_item_t    item_reg;
    logic         result_valid_reg;
    qor_result_t  result_reg;
    qor_result_t  result_next;
    qor_overlay_t ovl_reg;
    qor_overlay_t ovl_next;
    logic [31:0]  div_reg;
    logic [31:0]  div_next;
    logic         advance;

    logic q_ok;
    logic tick_stale;
    logic inst_match;
    logic gen_match;

    assign advance      = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready   = !item_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign q_ok       = quote_ok(item_reg);
    assign inst_match = item_reg.instrument == ovl_reg.instrument;
    assign gen_match  = item_reg.generation == ovl_reg.generation;
    assign tick_stale = ovl_reg.valid && gen_match && (item_reg.seq <= ovl_reg.seq);

    always_comb
    begin
        ovl_next = ovl_reg;
        div_next = div_reg;
        result_next = '0;
        result_next.action = ACT_IGNORED;
        case (item_reg.cmd)
            CMD_TICKER:
            begin
                if (q_ok && (item_reg.instrument == item_reg.canon_instrument) && !tick_stale)
                begin
                    ovl_next.valid      = 1'b1;
                    ovl_next.instrument = item_reg.instrument;
                    ovl_next.generation = item_reg.generation;
                    ovl_next.seq        = item_reg.seq;
                    ovl_next.stamp      = item_reg.stamp;
                    ovl_next.bid_price  = item_reg.bid_price;
                    ovl_next.bid_qty    = item_reg.bid_qty;
                    ovl_next.ask_price  = item_reg.ask_price;
                    ovl_next.ask_qty    = item_reg.ask_qty;
                    if (!shared_reg)
                    begin
                        result_next.action = ACT_TICKER_ONLY;
                    end
                    else if ((item_reg.generation != item_reg.canon_generation) ||
                             (item_reg.seq <= item_reg.canon_seq))
                    begin
                        ovl_next = '0;
                    end
                    else
                    begin
                        result_next.action = ACT_UPDATED;
                    end
                end
            end
            CMD_CANONICAL:
            begin
                if (shared_reg && ovl_reg.valid)
                begin
                    if (!inst_match || !gen_match || (item_reg.seq > ovl_reg.seq))
                    begin
                        ovl_next = '0;
                        result_next.action = ACT_CLEARED;
                    end
                    else if (item_reg.seq < ovl_reg.seq)
                    begin
                        result_next.action = ACT_PENDING;
                    end
                    else if ((item_reg.bid_price == ovl_reg.bid_price) &&
                             (item_reg.bid_qty == ovl_reg.bid_qty) &&
                             (item_reg.ask_price == ovl_reg.ask_price) &&
                             (item_reg.ask_qty == ovl_reg.ask_qty))
                    begin
                        ovl_next = '0;
                        result_next.action = ACT_CLEARED;
                    end
                    else
                    begin
                        if (div_reg != DIV_MAX)
                        begin
                            div_next = div_reg + 32'd1;
                        end
                        ovl_next.valid = 1'b0;
                        result_next.action = ACT_DIVERGENCE;
                    end
                end
            end
            CMD_QUERY:
            begin
                result_next.use_overlay = shared_reg && ovl_reg.valid && gen_match &&
                                          inst_match && (ovl_reg.seq > item_reg.seq);
                result_next.canonical_ok = q_ok;
            end
            default:
            begin
                result_next.action = ACT_IGNORED;
            end
        endcase
        result_next.divergences   = div_next;
        result_next.overlay_valid = ovl_next.valid;
        result_next.out_seq       = ovl_next.seq;
        result_next.out_stamp     = ovl_next.stamp;
        result_next.out_bid_price = ovl_next.bid_price;
        result_next.out_bid_qty   = ovl_next.bid_qty;
        result_next.out_ask_price = ovl_next.ask_price;
        result_next.out_ask_qty   = ovl_next.ask_qty;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shared_reg       <= 1'b1;
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            ovl_reg          <= '0;
            div_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                shared_reg <= cfg_wdata;
            end
            if (item_ready)
            begin
                item_valid_reg <= item_valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
                ovl_reg          <= ovl_next;
                div_reg          <= div_next;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    `QOR_ASSERT_NEXT(a_div_hold, !advance, $stable(div_reg), "divergence count moved without a beat")
    `QOR_ASSERT_NOW(a_div_drop, result_valid && (result.action == ACT_DIVERGENCE), !result.overlay_valid, "overlay still valid after divergence")
    `QOR_ASSERT_NOW(a_clear_zero, result_valid && (result.action == ACT_CLEARED), (result.out_seq == 64'd0) && (result.out_stamp == 64'd0), "cleared overlay kept its header")
    `QOR_ASSERT_NOW(a_use_valid, result_valid && result.use_overlay, result.overlay_valid && (result.action == ACT_IGNORED), "overlay used while not valid")
    `QOR_ASSERT_NOW(a_empty_ready, !item_valid_reg, item_ready, "input register empty but not ready")

endmodule

// File: verif/tb.sv
// Testbench for quote_overlay_reconciler_top: predicted overlay results, random beats and stalls
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qor_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [31:0] ONES32 = 32'hFFFF_FFFF;
    localparam logic [63:0] ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAXPOS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MINNEG = 64'h8000_0000_0000_0000;

    class overlay_scoreboard;
        bit           shared;
        qor_overlay_t held;
        logic [31:0]  div_count;
        qor_result_t  due[$];
        int           errors;

        function new();
            shared = 1'b1;
            held = '0;
            div_count = '0;
            errors = 0;
        endfunction

        function int pending();
            return due.size();
        endfunction

        function bit quote_good(qor_item_t it);
            return !it.bid_price[63] && !it.bid_qty[63] &&
                   !it.ask_price[63] && !it.ask_qty[63] &&
                   ($signed(it.bid_price) < $signed(it.ask_price));
        endfunction

        function qor_action_t take_ticker(qor_item_t it);
            if (!quote_good(it) || it.instrument != it.canon_instrument)
                return ACT_IGNORED;
            if (held.valid && it.generation == held.generation && it.seq <= held.seq)
                return ACT_IGNORED;
            held.valid = 1'b1;
            held.instrument = it.instrument;
            held.generation = it.generation;
            held.seq = it.seq;
            held.stamp = it.stamp;
            held.bid_price = it.bid_price;
            held.bid_qty = it.bid_qty;
            held.ask_price = it.ask_price;
            held.ask_qty = it.ask_qty;
            if (!shared)
                return ACT_TICKER_ONLY;
            if (it.generation != it.canon_generation || it.seq <= it.canon_seq)
            begin
                held = '0;
                return ACT_IGNORED;
            end
            return ACT_UPDATED;
        endfunction

        function qor_action_t reconcile(qor_item_t it);
            if (!shared || !held.valid)
                return ACT_IGNORED;
            if (it.instrument != held.instrument || it.generation != held.generation)
            begin
                held = '0;
                return ACT_CLEARED;
            end
            if (it.seq < held.seq)
                return ACT_PENDING;
            if (it.seq > held.seq)
            begin
                held = '0;
                return ACT_CLEARED;
            end
            if (it.bid_price == held.bid_price && it.bid_qty == held.bid_qty &&
                it.ask_price == held.ask_price && it.ask_qty == held.ask_qty)
            begin
                held = '0;
                return ACT_CLEARED;
            end
            if (div_count != DIV_MAX)
                div_count = div_count + 32'd1;
            held.valid = 1'b0;
            return ACT_DIVERGENCE;
        endfunction

        function void note_item(qor_item_t it);
            qor_result_t r;
            r = '0;
            r.action = ACT_IGNORED;
            case (it.cmd)
                CMD_TICKER:    r.action = take_ticker(it);
                CMD_CANONICAL: r.action = reconcile(it);
                CMD_QUERY:
                begin
                    r.use_overlay = shared && held.valid &&
                                    held.generation == it.generation &&
                                    held.instrument == it.instrument &&
                                    held.seq > it.seq;
                    r.canonical_ok = quote_good(it);
                end
                default: ;
            endcase
            r.divergences = div_count;
            r.overlay_valid = held.valid;
            r.out_seq = held.seq;
            r.out_stamp = held.stamp;
            r.out_bid_price = held.bid_price;
            r.out_bid_qty = held.bid_qty;
            r.out_ask_price = held.ask_price;
            r.out_ask_qty = held.ask_qty;
            due.push_back(r);
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_result(qor_result_t r);
            qor_result_t w;
            if (due.size() == 0)
            begin
                report("result beat with nothing pending");
                return;
            end
            w = due.pop_front();
            check_field("action", r.action, w.action);
            check_field("divergences", r.divergences, w.divergences);
            check_field("overlay_valid", r.overlay_valid, w.overlay_valid);
            check_field("use_overlay", r.use_overlay, w.use_overlay);
            check_field("canonical_ok", r.canonical_ok, w.canonical_ok);
            check_field("out_seq", r.out_seq, w.out_seq);
            check_field("out_stamp", r.out_stamp, w.out_stamp);
            check_field("out_bid_price", r.out_bid_price, w.out_bid_price);
            check_field("out_bid_qty", r.out_bid_qty, w.out_bid_qty);
            check_field("out_ask_price", r.out_ask_price, w.out_ask_price);
            check_field("out_ask_qty", r.out_ask_qty, w.out_ask_qty);
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        item_valid;
    logic        item_ready;
    qor_item_t   item;
    logic        result_valid;
    logic        result_ready;
    qor_result_t result;

    overlay_scoreboard sb;
    int          send_calm = 0;
    int          recv_calm = 0;
    logic [31:0] cur_inst;
    logic [31:0] cur_gen;
    logic [63:0] cur_seq;
    qor_item_t   last_tick;

    quote_overlay_reconciler_top uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #6 clk = ~clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
            calm = $urandom_range(8, 40);
        return $urandom_range(0, 15);
    endfunction

    function automatic qor_item_t mk(logic [1:0] cmd, logic [31:0] inst, gen,
                                     logic [63:0] seq, bp, bq, ap, aq,
                                     logic [31:0] ci, cg, logic [63:0] cs);
        qor_item_t it;
        it.cmd = cmd;
        it.instrument = inst;
        it.generation = gen;
        it.seq = seq;
        it.stamp = rand64();
        it.bid_price = bp;
        it.bid_qty = bq;
        it.ask_price = ap;
        it.ask_qty = aq;
        it.canon_instrument = ci;
        it.canon_generation = cg;
        it.canon_seq = cs;
        return it;
    endfunction

    function automatic qor_item_t with_quote(qor_item_t it, bit good);
        it.bid_price = rand64() >> 2;
        it.ask_price = it.bid_price + 64'($urandom_range(1, 1000));
        it.bid_qty = rand64() >> 1;
        it.ask_qty = ($urandom_range(0, 7) == 0) ? 64'd0 : rand64() >> 1;
        if (!good)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    it.bid_price = rand64();
                    it.bid_qty = rand64();
                    it.ask_price = rand64();
                    it.ask_qty = rand64();
                end
                1: it.ask_price = it.bid_price;
                default: it.bid_price = it.ask_price + 64'd1;
            endcase
        end
        return it;
    endfunction

    function automatic qor_item_t next_item();
        qor_item_t    it;
        logic [639:0] raw;
        int           pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            for (int k = 0; k < 20; k++)
                raw[k*32 +: 32] = $urandom;
            it = raw[$bits(qor_item_t)-1:0];
        end
        else if (pick < 48)
        begin
            if ($urandom_range(0, 19) == 0)
                cur_gen = cur_gen + 32'd1;
            if ($urandom_range(0, 29) == 0)
                cur_inst = $urandom_range(0, 3);
            it.cmd = CMD_TICKER;
            it.instrument = cur_inst;
            it.generation = cur_gen;
            it.seq = cur_seq + 64'($urandom_range(0, 5)) - 64'd1;
            if (it.seq > cur_seq)
                cur_seq = it.seq;
            it.stamp = rand64();
            it = with_quote(it, $urandom_range(0, 9) != 0);
            it.canon_instrument = ($urandom_range(0, 19) == 0) ? $urandom : it.instrument;
            it.canon_generation = ($urandom_range(0, 14) == 0) ? it.generation + 32'd1
                                                                : it.generation;
            it.canon_seq = ($urandom_range(0, 15) == 0) ? it.seq + 64'd1
                                                        : it.seq - 64'($urandom_range(0, 7));
            last_tick = it;
        end
        else if (pick < 82)
        begin
            it = last_tick;
            it.cmd = CMD_CANONICAL;
            it.stamp = rand64();
            if ($urandom_range(0, 9) == 0)
                it.instrument = it.instrument ^ 32'd1;
            if ($urandom_range(0, 9) == 0)
                it.generation = it.generation + 32'd1;
            it.seq = last_tick.seq + 64'($urandom_range(0, 4)) - 64'd2;
            if ($urandom_range(0, 1) == 1)
            begin
                case ($urandom_range(0, 3))
                    0: it.bid_price = it.bid_price + 64'd1;
                    1: it.bid_qty = it.bid_qty + 64'd1;
                    2: it.ask_price = it.ask_price + 64'd1;
                    default: it.ask_qty = it.ask_qty + 64'd1;
                endcase
            end
            it.canon_instrument = $urandom;
            it.canon_generation = $urandom;
            it.canon_seq = rand64();
        end
        else
        begin
            it = last_tick;
            it.cmd = (pick < 96) ? CMD_QUERY : CMD_UNUSED;
            it.stamp = rand64();
            it.seq = last_tick.seq + 64'($urandom_range(0, 4)) - 64'd3;
            if ($urandom_range(0, 9) == 0)
                it.generation = it.generation + 32'd1;
            it = with_quote(it, $urandom_range(0, 2) != 0);
        end
        return it;
    endfunction

    task automatic send_item(qor_item_t it);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_ready !== 1'b1);
        sb.note_item(it);
        @(negedge clk);
    endtask

    task automatic write_shared(bit v);
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.shared = v;
    endtask

    initial
    begin
        logic [31:0] ins;
        logic [31:0] gn;
        logic [63:0] sq;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_ready = 1'b0;
        sb = new();
        cur_inst = 32'd1;
        cur_gen = 32'd5;
        cur_seq = 64'd1000;
        last_tick = '0;
        ins = 32'h0000_1234;
        gn = 32'd7;
        sq = 64'd100;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_shared(1'b1);
        send_item(mk(CMD_QUERY, ins, gn, sq, 10, 5, 20, 5, 0, 0, 0));
        send_item(mk(CMD_TICKER, ins, gn, sq, ONES64, 5, 20, 5, ins, gn, sq - 1));
        send_item(mk(CMD_TICKER, ins, gn, sq, 10, 5, 20, 5, ins + 1, gn, sq - 1));
        send_item(mk(CMD_TICKER, ins, gn, sq, 10, 5, 20, 5, ins, gn, sq - 1));
        send_item(mk(CMD_TICKER, ins, gn, sq, 11, 5, 20, 5, ins, gn, sq - 1));
        send_item(mk(CMD_QUERY, ins, gn, sq - 1, 10, 5, 20, 5, 0, 0, 0));
        send_item(mk(CMD_CANONICAL, ins, gn, sq - 1, 10, 5, 20, 5, 0, 0, 0));
        send_item(mk(CMD_CANONICAL, ins, gn, sq, 10, 5, 21, 5, 0, 0, 0));
        send_item(mk(CMD_QUERY, ins, gn, sq - 1, 10, 5, 20, 5, 0, 0, 0));
        send_item(mk(CMD_TICKER, ins, gn, sq + 1, 10, 5, 20, 5, ins, gn, sq));
        send_item(mk(CMD_CANONICAL, ins, gn, sq + 1, 10, 5, 20, 5, 0, 0, 0));
        send_item(mk(CMD_TICKER, ins, gn, sq + 2, 10, 5, 20, 5, ins, gn, sq));
        send_item(mk(CMD_CANONICAL, ins + 1, gn, sq + 2, 10, 5, 20, 5, 0, 0, 0));
        send_item(mk(CMD_TICKER, ins, gn, sq + 3, 10, 5, 20, 5, ins, gn, sq));
        send_item(mk(CMD_CANONICAL, ins, gn, sq + 9, 10, 5, 20, 5, 0, 0, 0));
        send_item(mk(CMD_TICKER, ins, gn, sq + 4, 10, 5, 20, 5, ins, gn, sq + 4));
        send_item(mk(CMD_TICKER, ins, gn, sq + 5, 10, 5, 20, 5, ins, gn + 1, sq));
        send_item(mk(CMD_UNUSED, ins, gn, sq, 10, 5, 20, 5, ins, gn, sq));
        send_item(mk(CMD_TICKER, ONES32, ONES32, ONES64, 0, MAXPOS, MAXPOS, 0,
                     ONES32, ONES32, ONES64 - 1));
        send_item(mk(CMD_QUERY, ONES32, ONES32, ONES64 - 1, MINNEG, 0, MINNEG, 0,
                     0, 0, 0));
        send_item(mk(CMD_QUERY, ins, gn, sq, 5, 1, 5, 1, 0, 0, 0));
        send_item(mk(CMD_CANONICAL, ONES32, ONES32, ONES64, 0, MAXPOS, MAXPOS, 0,
                     0, 0, 0));
        write_shared(1'b0);
        send_item(mk(CMD_TICKER, ins, gn, sq + 10, 10, 5, 20, 5, ins, gn, sq + 20));
        send_item(mk(CMD_CANONICAL, ins, gn, sq + 10, 10, 5, 21, 5, 0, 0, 0));
        send_item(mk(CMD_QUERY, ins, gn, sq, 10, 5, 20, 5, 0, 0, 0));

        for (int p = 0; p < 6; p++)
        begin
            write_shared(p % 2 == 0);
            repeat (150) send_item(next_item());
        end

        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (sb.errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = draw_wait(recv_calm);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (result_valid !== 1'b1);
            sb.check_result(result);
            @(negedge clk);
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
